@@ rtl/sgt_pkg.sv @@
package sgt_pkg;

   // Table geometry.
   localparam int SESSION_COUNT = 1024;
   localparam int SESSION_W     = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;

   // Field widths.
   localparam int ID_W  = 10;
   localparam int SEQ_W = 32;
   localparam int LEN_W = 16;
   localparam int CNT_W = 64;

   // Sessions at or above this limit leave the table untouched.
   localparam logic [ID_W:0] SESSION_LIMIT = (ID_W + 1)'(SESSION_COUNT);

   // Stream widths, padded to whole bytes.
   localparam int REQ_BITS    = ID_W + SEQ_W + LEN_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ID_W + SEQ_W + 4 * CNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // One table entry.
   typedef struct packed {
      logic [SEQ_W-1:0] last_seq;
      logic [CNT_W-1:0] packets;
      logic [CNT_W-1:0] bytes;
      logic [CNT_W-1:0] gaps;
      logic [CNT_W-1:0] drops;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic calc;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_sts_type;

endpackage

@@ rtl/sgt_ctrl.sv @@
module sgt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sgt_pkg::dp_sts_type sts,
   output sgt_pkg::ctl_cmd_type cmd
);
   import sgt_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // Hold here until the result register can take the new beat.
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/sgt_datapath.sv @@
module sgt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sgt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sgt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [0:0]                        rsp_tuser,
   input  sgt_pkg::ctl_cmd_type              cmd,
   output sgt_pkg::dp_sts_type               sts
);
   import sgt_pkg::*;

   entry_type table_mem [SESSION_COUNT];

   logic [SESSION_W-1:0] clear_cnt_ff;
   logic [ID_W-1:0]      sid_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic [LEN_W-1:0]     len_ff;
   logic                 in_range_ff;
   entry_type            rd_ff;
   logic                 gap_ff;
   logic [SEQ_W-1:0]     mag_ff;

   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [0:0]              rsp_user_ff;

   logic [ID_W-1:0]      req_sid;
   logic [SEQ_W-1:0]     diff;
   logic                 gap_in;
   logic [SEQ_W-1:0]     mag_in;
   entry_type            upd;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic                 mem_we;
   logic [SESSION_W-1:0] mem_addr;
   entry_type            mem_wdata;

   assign req_sid = req_tdata[ID_W-1:0];

   // Sequence check on the entry read back from the table.
   always_comb begin
      diff   = seq_ff - rd_ff.last_seq;
      gap_in = in_range_ff && (rd_ff.last_seq != '0) && (diff != SEQ_W'(1));
      if (!gap_in) begin
         mag_in = '0;
      end else if (diff[SEQ_W-1]) begin
         mag_in = '0 - diff;
      end else begin
         mag_in = diff;
      end
   end

   always_comb begin
      upd.last_seq = seq_ff;
      upd.packets  = rd_ff.packets + CNT_W'(1);
      upd.bytes    = rd_ff.bytes + CNT_W'(len_ff);
      upd.gaps     = rd_ff.gaps + CNT_W'(gap_ff);
      upd.drops    = rd_ff.drops + CNT_W'(mag_ff);
      rsp_data_in  = '0;
      rsp_data_in[ID_W-1:0] = sid_ff;
      if (in_range_ff) begin
         rsp_data_in[RSP_BITS-1:ID_W] = {upd.drops, upd.gaps, upd.bytes, upd.packets, mag_ff};
      end
   end

   always_comb begin
      mem_we    = cmd.clear_wr || (cmd.commit && in_range_ff);
      mem_addr  = cmd.clear_wr ? clear_cnt_ff : sid_ff[SESSION_W-1:0];
      mem_wdata = cmd.clear_wr ? entry_type'('0) : upd;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.capture) begin
         rd_ff <= table_mem[req_sid[SESSION_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sid_ff      <= req_sid;
         seq_ff      <= req_tdata[ID_W+SEQ_W-1:ID_W];
         len_ff      <= req_tdata[REQ_BITS-1:ID_W+SEQ_W];
         in_range_ff <= ({1'b0, req_sid} < SESSION_LIMIT);
      end
      if (cmd.calc) begin
         gap_ff <= gap_in;
         mag_ff <= mag_in;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clear_cnt_ff <= clear_cnt_ff + SESSION_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_last = (clear_cnt_ff == SESSION_W'(SESSION_COUNT - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ rtl/session_sequence_gap_tracker_top.sv @@
// Per-session sequence gap tracker.
// The request channel (req_) carries one beat per mirrored packet: session id,
// sequence number and payload length. The block keeps a table of counters for
// every session and returns one response beat (rsp_) per request with the
// session's updated packet, byte, gap and dropped totals, the gap magnitude
// and, on tuser, a flag that says whether this packet broke the sequence.
// The table entry is read on the edge that takes the request beat and checked in
// the next cycle; the check result is registered, and the entry is written back,
// once the response register is free, together with the loading of that register,
// which raises rsp_tvalid.
// The table has a single read and a single write port and each packet is a
// read-modify-write on it, so the block takes no new request until the last one
// has reached its write-back and loaded the response register.
// After reset the table is cleared one entry per cycle, all 1024 entries,
// and req_tready stays low until that pass is finished.
// The response sits in an output register; if the receiver holds rsp_tready
// low, the next request is still accepted and worked up to the write-back,
// where it waits until the pending response beat has been taken.
module session_sequence_gap_tracker_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // session_id [9:0], sequence_number [41:10], payload_length [57:42]
   input  logic [sgt_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // session_out [9:0], gap_magnitude [41:10], packet_total [105:42],
   // byte_total [169:106], gap_events [233:170], dropped_total [297:234]
   output logic [sgt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // gap_seen [0]
   output logic [0:0]                      rsp_tuser
);
   import sgt_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // The controller sequences clearing, capture, check and write-back.
   sgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the session table, the arithmetic and the response register.
   sgt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ rtl/sgt_checker.sv @@
module sgt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sgt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser
);
   import sgt_pkg::*;

   // A stalled response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Without a gap the reported magnitude is zero.
   a_no_gap_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[ID_W+SEQ_W-1:ID_W] == '0)
      else $error("gap magnitude without gap flag");

   // A magnitude never exceeds two to the 31st.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[ID_W+SEQ_W-1] && (rsp_tdata[ID_W+SEQ_W-2:ID_W] != '0)))
      else $error("gap magnitude out of range");

   // Reset starts the clearing pass, which refuses requests.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during table clear");

   // Only one packet is in the table update at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken during update");

endmodule

bind session_sequence_gap_tracker_top sgt_checker u_sgt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
